FILE: rtl/core/fast_sine_cosine_macros.svh
// assertion macros shared by the checker
`ifndef FAST_SINE_COSINE_MACROS_SVH
`define FAST_SINE_COSINE_MACROS_SVH

// implication checked outside reset
`define FSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fast_sine_cosine: check failed");

// next-cycle implication, also seen during reset
`define FSC_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fast_sine_cosine: check failed");

`endif

FILE: rtl/core/fsc_pkg.sv
package fsc_pkg;

    localparam int ANGLE_W = 24;
    localparam int OUT_W   = 16;
    // angle in q24 plus a guard bit for the quarter-turn offset
    localparam int ARG_W   = ANGLE_W + 9;

    localparam logic [25:0] PI_Q24      = 26'd52707179;
    localparam logic [24:0] HALF_PI_Q24 = 25'd26353589;
    localparam logic [14:0] P_Q16       = 15'd14746;
    localparam logic [30:0] ONE_Q30     = 31'd1 << 30;
    localparam int          OUT_LIM     = 16384;
    localparam logic [14:0] OUT_MAX     = 15'(OUT_LIM);

    // reciprocals of pi, rounded down so the estimates never overshoot
    localparam logic [14:0] RECIP_P = 15'((64'd1 << 40) / 64'(PI_Q24));
    localparam logic [30:0] RECIP_T = 31'((64'd1 << 56) / 64'(PI_Q24));

    // pipeline stages
    localparam int ST_ABS   = 0;
    localparam int ST_QEST  = 1;
    localparam int ST_QREM  = 2;
    localparam int ST_QFIX  = 3;
    localparam int ST_TEST  = 4;
    localparam int ST_TLO   = 5;
    localparam int ST_TFIX  = 6;
    localparam int ST_PARAB = 7;
    localparam int ST_SQ    = 8;
    localparam int ST_PREC  = 9;
    localparam int ST_OUT   = 10;
    localparam int NSTAGE   = 11;

    typedef logic [NSTAGE-1:0] t_stage_en;

endpackage

FILE: rtl/core/fast_sine_cosine.sv
// channel   | valid    | ready    | payload
// ----------+----------+----------+---------------------------
// angle in  | i_valid  | o_ready  | i_angle   (q7.16 signed)
// result    | o_valid  | i_ready  | o_sine, o_cosine (q1.14)
//
// one beat per cycle sustained while i_ready is high; each pipeline stage is one register
// the two lanes (sine, and sine of angle plus pi/2) run side by side
// reset clears the stage valid bits only; payload registers are not reset
// each stage holds while the stage after it is full and stalled, so empty
// stages fill up under a stall and o_ready drops only when all are full

module fast_sine_cosine import fsc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [OUT_W-1:0]   o_sine,
    output logic signed [OUT_W-1:0]   o_cosine
);

    t_stage_en r_valid;
    t_stage_en n_valid;
    t_stage_en w_en;

    logic signed [ARG_W-1:0] w_sin_arg;
    logic signed [ARG_W-1:0] w_cos_arg;

    // stage k may load when empty or when its content moves on
    always_comb begin
        w_en[NSTAGE-1] = !r_valid[NSTAGE-1] || i_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_en[0]) begin
            n_valid[0] = i_valid;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (w_en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_valid[NSTAGE-1];

    // widen to q24
    assign w_sin_arg = {i_angle[ANGLE_W-1], i_angle, 8'b0};
    assign w_cos_arg = w_sin_arg + $signed({8'b0, HALF_PI_Q24});

    fsc_lane u_sin (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_arg    (w_sin_arg),
        .o_result (o_sine)
    );

    fsc_lane u_cos (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_arg    (w_cos_arg),
        .o_result (o_cosine)
    );

endmodule

FILE: rtl/core/fsc_lane.sv
module fsc_lane import fsc_pkg::*; (
    input  logic                    i_clk,
    input  t_stage_en               i_en,
    input  logic signed [ARG_W-1:0] i_arg,
    output logic signed [OUT_W-1:0] o_result
);

    logic        r_neg0, r_neg1, r_neg2, r_neg3, r_neg4, r_neg5;
    logic        r_neg6, r_neg7, r_neg8, r_neg9;
    logic [31:0] r_m0, r_m1;
    logic [6:0]  r_q1;
    logic [26:0] r_r2;
    logic [25:0] r_r3;
    logic [29:0] r_t4, r_t5, r_t6;
    logic [26:0] r_lo5;
    logic [30:0] r_y7, r_y8, r_y9;
    logic [30:0] r_yy8;
    logic [29:0] r_pe9;
    logic signed [OUT_W-1:0] r_res;

    logic [ARG_W-1:0] w_negarg;
    logic [30:0]      w_qprod;
    logic [31:0]      w_qpi;
    logic [31:0]      w_r0;
    logic [56:0]      w_tprod;
    logic [26:0]      w_tpi;
    logic [26:0]      w_rem;
    logic [30:0]      w_omt;
    logic [60:0]      w_yprod;
    logic [61:0]      w_yy;
    logic [30:0]      w_e;
    logic [45:0]      w_pe;
    logic [30:0]      w_z;
    logic [30:0]      w_zr;
    logic [14:0]      w_mag;
    logic [14:0]      w_magc;

    assign w_negarg = ARG_W'(0) - i_arg;

    always_ff @(posedge i_clk) if (i_en[ST_ABS]) begin
        r_neg0 <= i_arg[ARG_W-1];
        r_m0   <= i_arg[ARG_W-1] ? w_negarg[31:0] : i_arg[31:0];
    end

    // period estimate, low by at most one
    assign w_qprod = 31'(r_m0[31:16]) * 31'(RECIP_P);

    always_ff @(posedge i_clk) if (i_en[ST_QEST]) begin
        r_q1   <= w_qprod[30:24];
        r_m1   <= r_m0;
        r_neg1 <= r_neg0;
    end

    assign w_qpi = 32'(r_q1) * 32'(PI_Q24);
    assign w_r0  = r_m1 - w_qpi;

    always_ff @(posedge i_clk) if (i_en[ST_QREM]) begin
        r_r2   <= w_r0[26:0];
        r_neg2 <= r_neg1 ^ r_q1[0];
    end

    // one more period when the estimate fell short
    always_ff @(posedge i_clk) if (i_en[ST_QFIX]) begin
        if (r_r2 >= 27'(PI_Q24)) begin
            r_r3   <= 26'(r_r2 - 27'(PI_Q24));
            r_neg3 <= !r_neg2;
        end else begin
            r_r3   <= r_r2[25:0];
            r_neg3 <= r_neg2;
        end
    end

    assign w_tprod = 57'(r_r3) * 57'(RECIP_T);

    always_ff @(posedge i_clk) if (i_en[ST_TEST]) begin
        r_t4   <= w_tprod[55:26];
        r_neg4 <= r_neg3;
    end

    // r*2^30 has zero low bits, so the low bits of t*pi give the remainder
    assign w_tpi = 27'(r_t4[26:0]) * 27'(PI_Q24);

    always_ff @(posedge i_clk) if (i_en[ST_TLO]) begin
        r_lo5  <= w_tpi;
        r_t5   <= r_t4;
        r_neg5 <= r_neg4;
    end

    assign w_rem = 27'(0) - r_lo5;

    always_ff @(posedge i_clk) if (i_en[ST_TFIX]) begin
        r_t6   <= r_t5 + 30'(w_rem >= 27'(PI_Q24));
        r_neg6 <= r_neg5;
    end

    assign w_omt   = ONE_Q30 - 31'(r_t6);
    assign w_yprod = 61'(r_t6) * 61'(w_omt);

    always_ff @(posedge i_clk) if (i_en[ST_PARAB]) begin
        r_y7   <= w_yprod[58:28];
        r_neg7 <= r_neg6;
    end

    assign w_yy = 62'(r_y7) * 62'(r_y7);

    always_ff @(posedge i_clk) if (i_en[ST_SQ]) begin
        r_yy8  <= w_yy[60:30];
        r_y8   <= r_y7;
        r_neg8 <= r_neg7;
    end

    assign w_e  = r_y8 - r_yy8;
    assign w_pe = 46'(w_e) * 46'(P_Q16);

    always_ff @(posedge i_clk) if (i_en[ST_PREC]) begin
        r_pe9  <= w_pe[45:16];
        r_y9   <= r_y8;
        r_neg9 <= r_neg8;
    end

    // round to q1.14, halves up, clamp to OUT_MAX, then apply the sign
    assign w_z    = r_y9 - 31'(r_pe9);
    assign w_zr   = w_z + (31'd1 << 15);
    assign w_mag  = w_zr[30:16];
    assign w_magc = (w_mag > OUT_MAX) ? OUT_MAX : w_mag;

    always_ff @(posedge i_clk) if (i_en[ST_OUT]) begin
        r_res <= r_neg9 ? (OUT_W'(0) - OUT_W'(w_magc)) : OUT_W'(w_magc);
    end

    assign o_result = r_res;

endmodule

FILE: rtl/core/fsc_checker.sv
`include "fast_sine_cosine_macros.svh"

module fsc_checker import fsc_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic signed [OUT_W-1:0]   o_sine,
    input logic signed [OUT_W-1:0]   o_cosine
);

    logic w_stall;
    logic w_in_range;
    logic w_large;

    assign w_stall    = o_valid && !i_ready;
    assign w_in_range = (o_sine <= OUT_LIM) && (o_sine >= -OUT_LIM) &&
                        (o_cosine <= OUT_LIM) && (o_cosine >= -OUT_LIM);
    assign w_large    = (o_sine >= 8192) || (o_sine <= -8192) ||
                        (o_cosine >= 8192) || (o_cosine <= -8192);

    // nothing comes out right after reset
    `FSC_ASSERT_NXT(a_rst_empty, i_clk, !i_rst_n, !o_valid)

    // a stalled result beat holds
    `FSC_ASSERT_NXT(a_hold, i_clk, i_rst_n && w_stall, o_valid && $stable({o_sine, o_cosine}))

    // results stay in q1.14 unit range
    `FSC_ASSERT_IMP(a_range, i_clk, i_rst_n, o_valid, w_in_range)

    // sine and cosine cannot both be small
    `FSC_ASSERT_IMP(a_unit, i_clk, i_rst_n, o_valid, w_large)

endmodule

bind fast_sine_cosine fsc_checker u_fsc_checker (.*);
